/* rtl/fcsr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsr_pkg
// Types and codes shared by the filled-circle span rasterizer modules.
// ----------------------------------------------------------------------------
package fcsr_pkg;

    // Input item kinds, carried on s_tuser
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Field widths fixed by the item formats
    localparam int CENTER_W = 10;
    localparam int RADIUS_W = 9;
    localparam int VALUE_W  = 2;
    localparam int STEP_X_W = 9;
    localparam int STEP_Y_W = 10;
    localparam int ACCUM_W  = 12;
    localparam int COORD_W  = 12;
    localparam int CALC_W   = 13;

    // Accumulator starts at radius / 16: a shift by four
    localparam int ACCUM_SHIFT = 4;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    // One octant step, handed from the front end to the span emitter
    typedef struct packed {
        logic [STEP_X_W-1:0] x;
        logic [STEP_Y_W-1:0] y;
        logic [CENTER_W-1:0] mx;
        logic [CENTER_W-1:0] my;
        logic [VALUE_W-1:0]  value;
        logic                done;
    } step_rec_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Span phases within one step
    localparam logic [1:0] PH_RIGHT_X = 2'd0;
    localparam logic [1:0] PH_LEFT_X  = 2'd1;
    localparam logic [1:0] PH_RIGHT_Y = 2'd2;
    localparam logic [1:0] PH_LEFT_Y  = 2'd3;

endpackage

/* rtl/filled_circle_span_rasterizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filled_circle_span_rasterizer
// Filled-circle rasterizer emitting vertical spans by the integer midpoint walk.
// ----------------------------------------------------------------------------
// A start item (s_tuser = 0) loads the center, radius and cell value and
// emits nothing; it restarts the walk even mid-circle. Each advance
// item (s_tuser = 1) while a circle is open yields four vertical spans, in the
// order column cx+x, cx-x (rows cy-y..cy+y), then cx+y, cx-y (rows cy-x..cy+x);
// the fourth span of the closing step carries m_tlast. An advance with no open
// circle is taken and dropped. The span emitter loads one span per cycle into
// the output register while the queue holds a step and the output is not
// stalled, so that register sets the sustained rate. In the cycle it accepts
// an advance, the front end pushes the current walk step into a two-entry
// queue and computes the next one, so input keeps flowing while results wait
// downstream. Centers are clamped to GRID_SIZE-1 and radii to RADIUS_MAX;
// span coordinates are not clipped and wrap as 12-bit two's complement values.
// ----------------------------------------------------------------------------
module filled_circle_span_rasterizer #(
    parameter int GRID_SIZE  = 1024,
    parameter int RADIUS_MAX = 511
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // center_x[9:0], center_y[19:10], radius[28:20],
                                   // cell_value[30:29], zero [31]
    input  logic        s_tuser,   // op: 0 start, 1 advance
    // Span items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // column[11:0], row_low[23:12], row_high[35:24],
                                   // span_value[37:36], zero [39:38]
    output logic        m_tlast    // last span of the circle
);

    fcsr_pkg::q_status_t q_status;
    fcsr_pkg::step_rec_t q_wdata, q_rdata;
    logic                q_push, q_pop;

    // Accept items and advance the walk
    fcsr_front #(
        .GRID_SIZE  (GRID_SIZE),
        .RADIUS_MAX (RADIUS_MAX)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    // Hold pending steps between the two sides
    fcsr_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .status  (q_status)
    );

    // Emit four spans per step
    fcsr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_rdata  (q_rdata),
        .q_status (q_status),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/fcsr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsr_front
// Accept items, hold the circle walk and push one step record per advance on an open circle.
// ----------------------------------------------------------------------------
module fcsr_front #(
    parameter int GRID_SIZE  = 1024,
    parameter int RADIUS_MAX = 511
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fcsr_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  fcsr_pkg::q_status_t           q_status,
    output logic                          q_push,
    output fcsr_pkg::step_rec_t           q_wdata
);

    logic [fcsr_pkg::STEP_X_W-1:0]       step_x_reg, step_x_next;
    logic [fcsr_pkg::STEP_Y_W-1:0]       step_y_reg, step_y_next;
    logic signed [fcsr_pkg::ACCUM_W-1:0] error_accum_reg, error_accum_next;
    logic [fcsr_pkg::CENTER_W-1:0]       held_cx_reg, held_cx_next;
    logic [fcsr_pkg::CENTER_W-1:0]       held_cy_reg, held_cy_next;
    logic [fcsr_pkg::VALUE_W-1:0]        held_value_reg, held_value_next;
    logic                                busy_reg, busy_next;

    logic [fcsr_pkg::CENTER_W-1:0] in_cx, in_cy, sat_cx, sat_cy;
    logic [fcsr_pkg::RADIUS_W-1:0] in_r, sat_r;
    logic [fcsr_pkg::VALUE_W-1:0]  in_value;
    logic                          accept;

    logic signed [fcsr_pkg::CALC_W-1:0] x_s, ny_s, acc_sum, acc_diff, acc_n, nx_s;
    logic                               done;

    assign in_cx    = s_tdata[9:0];
    assign in_cy    = s_tdata[19:10];
    assign in_r     = s_tdata[28:20];
    assign in_value = s_tdata[30:29];

    // Saturate the start fields to the grid and radius bounds
    assign sat_cx = (32'(in_cx) >= 32'(GRID_SIZE)) ? fcsr_pkg::CENTER_W'(GRID_SIZE - 1) : in_cx;
    assign sat_cy = (32'(in_cy) >= 32'(GRID_SIZE)) ? fcsr_pkg::CENTER_W'(GRID_SIZE - 1) : in_cy;
    assign sat_r  = (32'(in_r) > 32'(RADIUS_MAX)) ? fcsr_pkg::RADIUS_W'(RADIUS_MAX) : in_r;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept && (s_tuser == fcsr_pkg::OP_ADVANCE) && busy_reg;

    // Midpoint step: y += 1, acc += y, pull x in when acc reaches x
    always_comb begin
        x_s      = $signed({4'b0, step_x_reg});
        ny_s     = $signed({3'b0, step_y_reg}) + 13'sd1;
        acc_sum  = $signed({error_accum_reg[fcsr_pkg::ACCUM_W-1], error_accum_reg}) + ny_s;
        acc_diff = acc_sum - x_s;
        if (acc_diff >= 0) begin
            acc_n = acc_diff;
            nx_s  = x_s - 13'sd1;
        end else begin
            acc_n = acc_sum;
            nx_s  = x_s;
        end
        done = nx_s < ny_s;
    end

    always_comb begin
        q_wdata.x     = step_x_reg;
        q_wdata.y     = step_y_reg;
        q_wdata.mx    = held_cx_reg;
        q_wdata.my    = held_cy_reg;
        q_wdata.value = held_value_reg;
        q_wdata.done  = done;
    end

    always_comb begin
        step_x_next      = step_x_reg;
        step_y_next      = step_y_reg;
        error_accum_next = error_accum_reg;
        held_cx_next     = held_cx_reg;
        held_cy_next     = held_cy_reg;
        held_value_next  = held_value_reg;
        busy_next        = busy_reg;
        if (accept && (s_tuser == fcsr_pkg::OP_START)) begin
            held_cx_next     = sat_cx;
            held_cy_next     = sat_cy;
            held_value_next  = in_value;
            step_x_next      = sat_r;
            step_y_next      = '0;
            error_accum_next = $signed({3'b0, sat_r >> fcsr_pkg::ACCUM_SHIFT});
            busy_next        = 1'b1;
        end else if (q_push) begin
            step_x_next      = nx_s[fcsr_pkg::STEP_X_W-1:0];
            step_y_next      = ny_s[fcsr_pkg::STEP_Y_W-1:0];
            error_accum_next = acc_n[fcsr_pkg::ACCUM_W-1:0];
            busy_next        = !done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_x_reg      <= '0;
            step_y_reg      <= '0;
            error_accum_reg <= '0;
            held_cx_reg     <= '0;
            held_cy_reg     <= '0;
            held_value_reg  <= '0;
            busy_reg        <= 1'b0;
        end else begin
            step_x_reg      <= step_x_next;
            step_y_reg      <= step_y_next;
            error_accum_reg <= error_accum_next;
            held_cx_reg     <= held_cx_next;
            held_cy_reg     <= held_cy_next;
            held_value_reg  <= held_value_next;
            busy_reg        <= busy_next;
        end
    end

endmodule

/* rtl/fcsr_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsr_queue
// Two-entry queue of step records between the front end and the emitter.
// ----------------------------------------------------------------------------
module fcsr_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  fcsr_pkg::step_rec_t wdata,
    input  logic                pop,
    output fcsr_pkg::step_rec_t rdata,
    output fcsr_pkg::q_status_t status
);

    fcsr_pkg::step_rec_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3) else $error("queue count beyond depth");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        status.full |-> !push) else $error("push into full queue");
`endif

endmodule

/* rtl/fcsr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsr_back
// Expand each step record into four vertical spans through an output register.
// ----------------------------------------------------------------------------
module fcsr_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  fcsr_pkg::step_rec_t            q_rdata,
    input  fcsr_pkg::q_status_t            q_status,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fcsr_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);

    logic [1:0] phase_reg, phase_next;
    logic       valid_reg, valid_next;
    logic [fcsr_pkg::M_TDATA_W-1:0] data_reg;
    logic       last_reg;
    logic       load;

    logic [fcsr_pkg::COORD_W-1:0] mx12, my12, x12, y12, col, lo, hi;
    logic                         is_last;

    assign load  = !q_status.empty && (!valid_reg || m_tready);
    assign q_pop = load && (phase_reg == fcsr_pkg::PH_LEFT_Y);

    assign mx12 = {2'b0, q_rdata.mx};
    assign my12 = {2'b0, q_rdata.my};
    assign x12  = {3'b0, q_rdata.x};
    assign y12  = {2'b0, q_rdata.y};

    always_comb begin
        is_last = 1'b0;
        unique case (phase_reg)
            fcsr_pkg::PH_RIGHT_X: begin
                col = mx12 + x12;
                lo  = my12 - y12;
                hi  = my12 + y12;
            end
            fcsr_pkg::PH_LEFT_X: begin
                col = mx12 - x12;
                lo  = my12 - y12;
                hi  = my12 + y12;
            end
            fcsr_pkg::PH_RIGHT_Y: begin
                col = mx12 + y12;
                lo  = my12 - x12;
                hi  = my12 + x12;
            end
            fcsr_pkg::PH_LEFT_Y: begin
                col     = mx12 - y12;
                lo      = my12 - x12;
                hi      = my12 + x12;
                is_last = q_rdata.done;
            end
        endcase
    end

    always_comb begin
        phase_next = load ? phase_reg + 2'd1 : phase_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {2'b0, q_rdata.value, hi, lo, col};
            last_reg <= is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= fcsr_pkg::PH_RIGHT_X;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

`ifndef SYNTH
    a_phase_has_record: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != fcsr_pkg::PH_RIGHT_X) |-> !q_status.empty)
        else $error("span phase advanced without a queued step");
`endif

endmodule
